/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_CLK_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bpt_pkg.sv */
// Shared types and constants for the breakpoint table.
// No dependencies; imported by every module of the block.
package bpt_pkg;

  localparam int LIST_DEPTH_DEF = 32;
  localparam int CPU_COUNT_DEF  = 2;
  localparam int ADDR_W         = 16;
  localparam int CNT_W          = 6;
  localparam int CAP_MAX        = 63;

  typedef enum logic [1:0] {
    ST_CHECKED = 2'd0,
    ST_ADDED   = 2'd1,
    ST_REMOVED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture a new transaction
    logic rd_en;      // read list entry
    logic rd_next;    // read at idx+1 instead of idx
    logic set_found;  // compare hit seen
    logic idx_inc;
    logic wr_move;    // write idx with the entry just read
    logic wr_append;  // write idx with the transaction address
    logic len_inc;
    logic len_dec;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cpu_ok;
    logic mode;
    logic at_end;     // idx reached list length
    logic hit;        // read data equals address
    logic more;       // idx+1 still inside the list
    logic room;       // list below capacity
  } stat_t;

endpackage

/* rtl/core/bpt_ctrl.sv */
// Sequencer for the breakpoint table: scan, compaction and append steps.
// Depends on bpt_pkg.
module bpt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bpt_pkg::stat_t st,
  output bpt_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  import bpt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LOOK    = 7'b0000010,
    S_CMP     = 7'b0000100,
    S_MOVE    = 7'b0001000,
    S_MOVE_WR = 7'b0010000,
    S_APPEND  = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!st.cpu_ok) begin
          state_next = S_FINISH;
        end else if (st.at_end) begin
          if (st.mode && st.room) begin
            state_next = S_APPEND;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (st.hit) begin
          cmd.set_found = 1'b1;
          state_next    = st.mode ? S_MOVE : S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_MOVE: begin
        if (st.more) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_MOVE_WR;
        end else begin
          cmd.len_dec = 1'b1;
          state_next  = S_FINISH;
        end
      end
      S_MOVE_WR: begin
        cmd.wr_move = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_MOVE;
      end
      S_APPEND: begin
        cmd.wr_append = 1'b1;
        cmd.len_inc   = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FINISH);

endmodule

/* rtl/core/bpt_datapath.sv */
// Breakpoint table datapath: list memory, per-processor lengths, result fields.
// Depends on bpt_pkg.
module bpt_datapath #(
  parameter int LIST_DEPTH = bpt_pkg::LIST_DEPTH_DEF,
  parameter int CPU_COUNT  = bpt_pkg::CPU_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bpt_pkg::cmd_t              cmd,
  input  logic                       mode,
  input  logic                       cpu_select,
  input  logic [bpt_pkg::ADDR_W-1:0] address,
  output bpt_pkg::stat_t             st,
  output logic                       match,
  output logic [1:0]                 status,
  output logic [bpt_pkg::CNT_W-1:0]  entry_count
);
  import bpt_pkg::*;

  localparam int MEM_DEPTH = CPU_COUNT * LIST_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CAPACITY  = (LIST_DEPTH > CAP_MAX) ? CAP_MAX : LIST_DEPTH;

  logic [ADDR_W-1:0] mem [MEM_DEPTH];
  logic [ADDR_W-1:0] rd_data;

  logic              mode_q;
  logic              cpu_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  idx;
  logic              found;
  logic              added;

  logic [CNT_W-1:0]  lens [CPU_COUNT];
  logic [CNT_W-1:0]  cur_len;
  logic              cpu_ok;
  logic [CNT_W:0]    idx_plus;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [ADDR_W-1:0] wr_data;
  status_t           status_code;

  assign cpu_ok   = (int'(cpu_q) < CPU_COUNT);
  assign idx_plus = {1'b0, idx} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    cur_len = '0;
    for (int c = 0; c < CPU_COUNT; c++) begin
      if (int'(cpu_q) == c) begin
        cur_len = lens[c];
      end
    end
  end

  // Transaction capture and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      cpu_q  <= cpu_select;
      addr_q <= address;
    end
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_plus[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      added <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
      added <= 1'b0;
    end else begin
      if (cmd.set_found) begin
        found <= 1'b1;
      end
      if (cmd.wr_append) begin
        added <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CPU_COUNT; c++) begin
        lens[c] <= '0;
      end
    end else begin
      for (int c = 0; c < CPU_COUNT; c++) begin
        if (int'(cpu_q) == c) begin
          if (cmd.len_inc) begin
            lens[c] <= lens[c] + CNT_W'(1);
          end else if (cmd.len_dec) begin
            lens[c] <= lens[c] - CNT_W'(1);
          end
        end
      end
    end
  end

  // List memory: one write port, one registered read port
  assign rd_addr = AW'(int'(cpu_q) * LIST_DEPTH
                      + (cmd.rd_next ? int'(idx_plus) : int'(idx)));
  assign wr_addr = AW'(int'(cpu_q) * LIST_DEPTH + int'(idx));
  assign wr_data = cmd.wr_append ? addr_q : rd_data;

  always_ff @(posedge clk) begin
    if (cmd.wr_move || cmd.wr_append) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    st.cpu_ok = cpu_ok;
    st.mode   = mode_q;
    st.at_end = (idx >= cur_len);
    st.hit    = (rd_data == addr_q);
    st.more   = (idx_plus < {1'b0, cur_len});
    st.room   = (cur_len < CNT_W'(CAPACITY));
  end

  always_comb begin
    if (!cpu_ok || !mode_q) begin
      status_code = ST_CHECKED;
    end else if (found) begin
      status_code = ST_REMOVED;
    end else if (added) begin
      status_code = ST_ADDED;
    end else begin
      status_code = ST_FULL;
    end
  end

  assign match       = found;
  assign status      = status_code;
  assign entry_count = cpu_ok ? cur_len : '0;

endmodule

/* rtl/core/breakpoint_table.sv */
// Breakpoint table top level. A check scans the selected list until a hit or its end;
// a removal then moves each later entry down by one, and an append writes the address
// at the end of the list. One transaction at a time: the next one is taken only once the
// sequencer is back in idle after done. done is a one-cycle strobe, never stalled.
// Reset (rst, synchronous): list lengths to zero, sequencer to idle; memory not cleared.
module breakpoint_table #(
  parameter int LIST_DEPTH = bpt_pkg::LIST_DEPTH_DEF,
  parameter int CPU_COUNT  = bpt_pkg::CPU_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode,
  input  logic                       cpu_select,
  input  logic [bpt_pkg::ADDR_W-1:0] address,
  output logic                       done,
  output logic                       match,
  output logic [1:0]                 status,
  output logic [bpt_pkg::CNT_W-1:0]  entry_count
);
  import bpt_pkg::*;

  // Controller and datapath talk only through these two bundles.
  cmd_t  cmd;
  stat_t st;

  // Sequencer: idle -> look/compare loop over the selected list, then either
  // compaction (read idx+1, write idx), an append, or straight to finish.
  // A transaction is taken when start is high and busy is low.
  bpt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: holds the transaction, the packed lists in one memory (list c
  // starts at c*LIST_DEPTH), the per-processor lengths and the result fields,
  // which are valid while done is high.
  bpt_datapath #(
    .LIST_DEPTH (LIST_DEPTH),
    .CPU_COUNT  (CPU_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (mode),
    .cpu_select  (cpu_select),
    .address     (address),
    .st          (st),
    .match       (match),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

/* rtl/core/bpt_checker.sv */
// Port-level checks for the breakpoint table, bound to the top level.
// Depends on bpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       match,
  input logic [1:0] status
);
  import bpt_pkg::*;

  logic rm_seen;   // result reports a removal
  logic add_try;   // result reports an append or a full refusal

  assign rm_seen = done && (status == ST_REMOVED);
  assign add_try = done && ((status == ST_ADDED) || (status == ST_FULL));

  `ASSERT_CLK_ALL(a_reset_idle, clk, rst |=> (!busy && !done), "not idle after reset")
  `ASSERT_CLK(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted but not busy")
  `ASSERT_CLK(a_done_pulse, clk, rst, done |=> !done, "result strobe longer than one cycle")
  `ASSERT_CLK(a_removed_hit, clk, rst, rm_seen |-> match, "removed without a match")
  `ASSERT_CLK(a_added_miss, clk, rst, add_try |-> (!match), "add attempt on a present address")

endmodule

bind breakpoint_table bpt_checker u_bpt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .match  (match),
  .status (status)
);
